### src/npic_pkg.sv
// shared constants, codes and helpers of the nested priority interrupt controller
package npic_pkg;

    localparam int SOURCES    = 16;
    localparam int PRIO_BITS  = 2;
    localparam int SRC_W      = 4;
    localparam int CNT_W      = 5;
    localparam int MAP_W      = 32;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [IN_USER_W-1:0] {
        F_TICK       = 3'd0,
        F_RAISE      = 3'd1,
        F_SRC_ENABLE = 3'd2,
        F_FLAG_CLEAR = 3'd3,
        F_GLOBAL_EN  = 3'd4,
        F_RETURN     = 3'd5
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIO_MAP  = 2'd0,
        CFG_AUTOCLEAR = 2'd1,
        CFG_REMEMBER  = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        WOP_ADD    = 1'b0,
        WOP_REMOVE = 1'b1
    } t_walk_op;

    // result item, dispatched in the lowest bit
    typedef struct packed {
        logic              pending_any;
        logic [MASK_W-1:0] flags;
        logic              global_enable;
        logic [SRC_W-1:0]  active_source;
        logic              active_valid;
        logic              return_error;
        logic              returned;
        logic [SRC_W-1:0]  dispatch_source;
        logic              dispatched;
    } t_result;

    // priority field of one source inside the priority map
    function automatic logic [PRIO_BITS-1:0] prio_of(
        input logic [MAP_W-1:0] map,
        input logic [SRC_W-1:0] src
    );
        int pos;
        pos = int'(src) * PRIO_BITS;
        return map[pos +: PRIO_BITS];
    endfunction

endpackage

### src/nested_priority_interrupt_controller.sv
// nested priority interrupt controller: flags, ordered pending list and nesting stack
//
// requests come in on the s_axis channel: s_axis_tuser carries the function code,
// s_axis_tdata the source index and the value bit. every request yields exactly one
// status result on the m_axis channel (dispatch, return, active handler, global
// enable, raised flags, pending indication).
// the block takes one request at a time: s_axis_tready is high only while idle.
// a request that leaves the pending list alone has its result valid the cycle after
// acceptance. a request that inserts into or removes from the pending list first walks
// the list in S_WALK, from position 0 up to the old pending count, and then shows its
// result in S_OUT; in both cases the block returns to idle once the result is taken.
// the walk is one read and at most one write of the pending-list memory per cycle.
// the result sits in an output register until m_axis_tready takes it; a stalled
// receiver holds the block and no new request is accepted meanwhile.
// configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and
// are meant for idle periods only.
// synchronous reset clears flags, enables, pending count, nesting depth, active
// handler, global enable and the return latch; the list and stack memories are not
// cleared, only entries below their counts are ever used.
module nested_priority_interrupt_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [npic_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // source[3:0], value[4]
    input  logic [npic_pkg::IN_USER_W-1:0]      s_axis_tuser,  // func[2:0]
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // dispatched[0], dispatch_source[4:1], returned[5], return_error[6],
    // active_valid[7], active_source[11:8], global_enable[12], flags[28:13],
    // pending_any[29]
    output logic [npic_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [npic_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [npic_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import npic_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [MAP_W-1:0]  r_prio_map, n_prio_map;
    logic [MASK_W-1:0] r_autoclear, n_autoclear;
    logic [MASK_W-1:0] r_remember, n_remember;

    // controller state
    logic [SOURCES-1:0] r_flags, n_flags;
    logic [SOURCES-1:0] r_en, n_en;
    logic [SOURCES-1:0] r_in_list, n_in_list;   // membership of the pending list
    logic [CNT_W-1:0]   r_pcount, n_pcount;
    logic [CNT_W-1:0]   r_depth, n_depth;
    logic               r_active, n_active;
    logic [SRC_W-1:0]   r_active_id, n_active_id;
    logic               r_global, n_global;
    logic               r_ret_latch, n_ret_latch;

    // list walk
    t_walk_op           r_op, n_op;
    logic [SRC_W-1:0]   r_key, n_key;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_wlen, n_wlen;
    logic               r_found, n_found;
    logic [SRC_W-1:0]   r_carry, n_carry;

    t_result            r_out, n_out;

    // pending list and nesting stack memories
    logic [SRC_W-1:0]   r_pend_mem [SOURCES];
    logic [SRC_W-1:0]   r_stack_mem [SOURCES];
    logic [SRC_W-1:0]   r_prd;      // registered pending-list read
    logic [SRC_W-1:0]   r_srd;      // registered stack-top read

    logic               w_pw_en;
    logic [SRC_W-1:0]   w_pw_addr;
    logic [SRC_W-1:0]   w_pw_data;
    logic [SRC_W-1:0]   w_prd_addr;
    logic [SRC_W-1:0]   w_srd_addr;
    logic               w_sw_en;

    logic               w_accept;
    t_func              w_func;
    logic [SRC_W-1:0]   w_src;
    logic               w_val;
    logic               w_go;
    logic               w_done;
    logic               w_disp;
    logic [SRC_W-1:0]   w_dsrc;
    logic               w_ret;
    logic               w_rerr;
    logic               w_walk;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_func   = t_func'(s_axis_tuser);
    assign w_src    = s_axis_tdata[SRC_W-1:0];
    assign w_val    = s_axis_tdata[SRC_W];
    assign w_done   = (r_pos == r_wlen);

    // walk reads one entry ahead; outside a walk the head is kept in r_prd
    assign w_prd_addr = (r_state == S_WALK) ? (r_pos[SRC_W-1:0] + 1'b1) : '0;
    // stack top, depth zero reads a don't-care entry
    assign w_srd_addr = SRC_W'(r_depth - 1'b1);

    always_ff @(posedge i_clk) begin
        r_prd <= r_pend_mem[w_prd_addr];
        r_srd <= r_stack_mem[w_srd_addr];
        if (w_pw_en) begin
            r_pend_mem[w_pw_addr] <= w_pw_data;
        end
        if (w_sw_en) begin
            r_stack_mem[r_depth[SRC_W-1:0]] <= r_active_id;
        end
    end

    // pending list walk: ordered insert with a ripple carry, or remove with shift-down
    always_comb begin
        w_pw_en   = 1'b0;
        w_pw_addr = r_pos[SRC_W-1:0];
        w_pw_data = r_carry;
        n_found   = r_found;
        n_carry   = r_carry;
        if (r_state == S_WALK) begin
            priority if (w_done) begin
                if (r_op == WOP_ADD) begin
                    w_pw_en   = 1'b1;
                    w_pw_addr = r_wlen[SRC_W-1:0];
                    w_pw_data = r_found ? r_carry : r_key;
                end
            end else if (r_op == WOP_ADD) begin
                priority if (r_found) begin
                    w_pw_en   = 1'b1;
                    w_pw_data = r_carry;
                    n_carry   = r_prd;
                end else if (prio_of(r_prio_map, r_key) > prio_of(r_prio_map, r_prd)) begin
                    w_pw_en   = 1'b1;
                    w_pw_data = r_key;
                    n_carry   = r_prd;
                    n_found   = 1'b1;
                end else begin
                    w_pw_en   = 1'b0;
                end
            end else begin
                priority if (r_found) begin
                    w_pw_en   = 1'b1;
                    w_pw_addr = SRC_W'(r_pos - 1'b1);
                    w_pw_data = r_prd;
                end else if (r_prd == r_key) begin
                    n_found   = 1'b1;
                end else begin
                    w_pw_en   = 1'b0;
                end
            end
        end
        if (w_accept) begin
            n_found = 1'b0;
        end
    end

    // request decode and sequencer
    always_comb begin
        n_state     = r_state;
        n_prio_map  = r_prio_map;
        n_autoclear = r_autoclear;
        n_remember  = r_remember;
        n_flags     = r_flags;
        n_en        = r_en;
        n_in_list   = r_in_list;
        n_pcount    = r_pcount;
        n_depth     = r_depth;
        n_active    = r_active;
        n_active_id = r_active_id;
        n_global    = r_global;
        n_ret_latch = r_ret_latch;
        n_op        = r_op;
        n_key       = r_key;
        n_pos       = r_pos;
        n_wlen      = r_wlen;
        n_out       = r_out;
        w_sw_en     = 1'b0;
        w_go        = 1'b0;
        w_disp      = 1'b0;
        w_dsrc      = '0;
        w_ret       = 1'b0;
        w_rerr      = 1'b0;
        w_walk      = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRIO_MAP:  n_prio_map  = i_cfg_data[MAP_W-1:0];
                CFG_AUTOCLEAR: n_autoclear = i_cfg_data[MASK_W-1:0];
                CFG_REMEMBER:  n_remember  = i_cfg_data[MASK_W-1:0];
                default:       n_prio_map  = r_prio_map;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_func)
                        F_TICK: begin
                            priority if (r_ret_latch) begin
                                n_ret_latch = 1'b0;
                                if (!r_active) begin
                                    w_rerr = 1'b1;
                                end else begin
                                    // leave the handler, autoclear its flag
                                    if (r_autoclear[r_active_id] && r_flags[r_active_id]) begin
                                        n_flags[r_active_id] = 1'b0;
                                        if (r_in_list[r_active_id]) begin
                                            n_in_list[r_active_id] = 1'b0;
                                            n_pcount = r_pcount - 1'b1;
                                            n_op     = WOP_REMOVE;
                                            n_key    = r_active_id;
                                            w_walk   = 1'b1;
                                        end
                                    end
                                    if (r_depth != '0) begin
                                        n_depth     = r_depth - 1'b1;
                                        n_active_id = r_srd;
                                    end else begin
                                        n_active    = 1'b0;
                                        n_active_id = '0;
                                    end
                                    n_global = 1'b1;
                                    w_ret    = 1'b1;
                                end
                            end else if (r_global && (r_pcount != '0)) begin
                                // head of the list is in r_prd
                                w_go = !r_active ||
                                       (prio_of(r_prio_map, r_prd) >
                                        prio_of(r_prio_map, r_active_id));
                                if (w_go) begin
                                    if (r_active && (r_depth < CNT_W'(SOURCES))) begin
                                        w_sw_en = 1'b1;
                                        n_depth = r_depth + 1'b1;
                                    end
                                    n_global        = 1'b0;
                                    n_active        = 1'b1;
                                    n_active_id     = r_prd;
                                    n_in_list[r_prd] = 1'b0;
                                    n_pcount        = r_pcount - 1'b1;
                                    n_op            = WOP_REMOVE;
                                    n_key           = r_prd;
                                    w_walk          = 1'b1;
                                    w_disp          = 1'b1;
                                    w_dsrc          = r_prd;
                                end
                            end else begin
                                w_go = 1'b0;
                            end
                        end
                        F_RAISE: begin
                            priority if (w_val && !r_flags[w_src]) begin
                                n_flags[w_src] = 1'b1;
                                if (r_en[w_src]) begin
                                    n_in_list[w_src] = 1'b1;
                                    n_pcount = r_pcount + 1'b1;
                                    n_op     = WOP_ADD;
                                    n_key    = w_src;
                                    w_walk   = 1'b1;
                                end
                            end else if (r_autoclear[w_src] && r_flags[w_src]) begin
                                // raise on a raised source, or low raise
                                n_flags[w_src] = 1'b0;
                                if (r_in_list[w_src]) begin
                                    n_in_list[w_src] = 1'b0;
                                    n_pcount = r_pcount - 1'b1;
                                    n_op     = WOP_REMOVE;
                                    n_key    = w_src;
                                    w_walk   = 1'b1;
                                end
                            end else begin
                                w_walk = 1'b0;
                            end
                        end
                        F_SRC_ENABLE: begin
                            if (r_en[w_src] != w_val) begin
                                n_en[w_src] = w_val;
                                priority if (w_val) begin
                                    if (r_flags[w_src] && r_remember[w_src]) begin
                                        n_in_list[w_src] = 1'b1;
                                        n_pcount = r_pcount + 1'b1;
                                        n_op     = WOP_ADD;
                                        n_key    = w_src;
                                        w_walk   = 1'b1;
                                    end
                                end else if (r_in_list[w_src]) begin
                                    n_in_list[w_src] = 1'b0;
                                    n_pcount = r_pcount - 1'b1;
                                    n_op     = WOP_REMOVE;
                                    n_key    = w_src;
                                    w_walk   = 1'b1;
                                end else begin
                                    w_walk = 1'b0;
                                end
                            end
                        end
                        F_FLAG_CLEAR: begin
                            if (w_val && r_flags[w_src]) begin
                                n_flags[w_src] = 1'b0;
                                if (r_in_list[w_src]) begin
                                    n_in_list[w_src] = 1'b0;
                                    n_pcount = r_pcount - 1'b1;
                                    n_op     = WOP_REMOVE;
                                    n_key    = w_src;
                                    w_walk   = 1'b1;
                                end
                            end
                        end
                        F_GLOBAL_EN: n_global    = w_val;
                        F_RETURN:    n_ret_latch = 1'b1;
                        default:     n_global    = r_global;
                    endcase

                    n_pos  = '0;
                    n_wlen = r_pcount;
                    n_out.dispatched      = w_disp;
                    n_out.dispatch_source = w_dsrc;
                    n_out.returned        = w_ret;
                    n_out.return_error    = w_rerr;
                    n_out.active_valid    = n_active;
                    n_out.active_source   = n_active_id;
                    n_out.global_enable   = n_global;
                    n_out.flags           = n_flags;
                    n_out.pending_any     = (n_pcount != '0);
                    n_state = w_walk ? S_WALK : S_OUT;
                end
            end
            S_WALK: begin
                n_pos = r_pos + 1'b1;
                if (w_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prio_map  <= '0;
            r_autoclear <= '1;
            r_remember  <= '1;
            r_flags     <= '0;
            r_en        <= '0;
            r_in_list   <= '0;
            r_pcount    <= '0;
            r_depth     <= '0;
            r_active    <= 1'b0;
            r_active_id <= '0;
            r_global    <= 1'b0;
            r_ret_latch <= 1'b0;
            r_pos       <= '0;
            r_wlen      <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prio_map  <= n_prio_map;
            r_autoclear <= n_autoclear;
            r_remember  <= n_remember;
            r_flags     <= n_flags;
            r_en        <= n_en;
            r_in_list   <= n_in_list;
            r_pcount    <= n_pcount;
            r_depth     <= n_depth;
            r_active    <= n_active;
            r_active_id <= n_active_id;
            r_global    <= n_global;
            r_ret_latch <= n_ret_latch;
            r_pos       <= n_pos;
            r_wlen      <= n_wlen;
            r_found     <= n_found;
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_carry <= n_carry;
        r_out   <= n_out;
    end

    // pending count tracks the membership bits
    a_count_matches_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount == CNT_W'($countones(r_in_list)))
        else $error("pending count differs from list membership");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(SOURCES))
        else $error("nesting depth beyond stack size");

    a_idle_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_active_id == '0))
        else $error("active id set with no active handler");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_pos <= r_wlen))
        else $error("list walk ran past the list end");

    a_dispatch_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.dispatched) |->
            (r_out.active_valid && !r_out.global_enable && !r_out.returned))
        else $error("dispatch result with inconsistent status");

endmodule

### tb/nested_priority_interrupt_controller_test.sv
// testbench of the nested priority interrupt controller: self-checking stream test with a status predictor
`timescale 1ns / 1ps

module nested_priority_interrupt_controller_test;

    import npic_pkg::*;

    // the two function codes the block leaves unassigned
    localparam logic [IN_USER_W-1:0] FUNC_SPARE_A = 3'd6;
    localparam logic [IN_USER_W-1:0] FUNC_SPARE_B = 3'd7;

    localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the block
    localparam int CYCLE_LIMIT = 200000; // a few times the slowest correct run
    localparam int SETTLE      = 40;     // settle time at the end, longer than the longest request latency

    // tracks the controller state and the status every request must produce
    class irq_status_checker;
        logic [MAP_W-1:0]  prio_map;
        logic [MASK_W-1:0] autoclear;
        logic [MASK_W-1:0] remember;
        logic [MASK_W-1:0] raised;
        logic [MASK_W-1:0] enabled;
        logic [SRC_W-1:0]  order [SOURCES];
        int                queued;
        logic [SRC_W-1:0]  nest [SOURCES];
        int                depth;
        bit                in_handler;
        logic [SRC_W-1:0]  handler;
        bit                gie;
        bit                ret_latch;
        t_result           status_due [$];
        int                mismatches;

        function new();
            prio_map   = '0;
            autoclear  = '1;
            remember   = '1;
            raised     = '0;
            enabled    = '0;
            queued     = 0;
            depth      = 0;
            in_handler = 0;
            handler    = '0;
            gie        = 0;
            ret_latch  = 0;
            mismatches = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PRIO_MAP:  prio_map  = data[MAP_W-1:0];
                CFG_AUTOCLEAR: autoclear = data[MASK_W-1:0];
                CFG_REMEMBER:  remember  = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PRIO_BITS-1:0] level_of(logic [SRC_W-1:0] s);
            logic [MAP_W-1:0] shifted;
            shifted = prio_map >> (PRIO_BITS * int'(s));
            return shifted[PRIO_BITS-1:0];
        endfunction

        // higher level first, arrival order among equals, no duplicates
        function void pend_insert(logic [SRC_W-1:0] s);
            int i;
            int at;
            for (i = 0; i < queued; i++) begin
                if (order[i] == s) return;
            end
            if (queued >= SOURCES) return;
            at = queued;
            for (i = 0; i < queued; i++) begin
                if (level_of(s) > level_of(order[i])) begin
                    at = i;
                    break;
                end
            end
            for (i = queued; i > at; i--) order[i] = order[i-1];
            order[at] = s;
            queued++;
        endfunction

        function void pend_drop(logic [SRC_W-1:0] s);
            int i;
            int j;
            for (i = 0; i < queued; i++) begin
                if (order[i] == s) begin
                    for (j = i; j + 1 < queued; j++) order[j] = order[j+1];
                    queued--;
                    return;
                end
            end
        endfunction

        function void flag_drop(logic [SRC_W-1:0] s);
            if (!raised[s]) return;
            raised[s] = 1'b0;
            pend_drop(s);
        endfunction

        // advance the state by one accepted request and queue its status
        function void take_request(logic [IN_USER_W-1:0] func, logic [SRC_W-1:0] src,
                                   logic val);
            t_result          r;
            logic [SRC_W-1:0] head;
            bit               go;
            r = '0;
            case (func)
                F_TICK: begin
                    if (ret_latch) begin
                        ret_latch = 0;
                        if (!in_handler) begin
                            r.return_error = 1'b1;
                        end else begin
                            if (autoclear[handler]) flag_drop(handler);
                            if (depth > 0) begin
                                depth--;
                                handler = nest[depth];
                            end else begin
                                in_handler = 0;
                                handler    = '0;
                            end
                            gie        = 1;
                            r.returned = 1'b1;
                        end
                    end else if (gie && queued > 0) begin
                        head = order[0];
                        go   = 1;
                        if (in_handler) begin
                            if (level_of(head) > level_of(handler)) begin
                                // a full stack loses the preempted handler
                                if (depth < SOURCES) begin
                                    nest[depth] = handler;
                                    depth++;
                                end
                            end else begin
                                go = 0;
                            end
                        end
                        if (go) begin
                            gie               = 0;
                            in_handler        = 1;
                            handler           = head;
                            pend_drop(head);
                            r.dispatched      = 1'b1;
                            r.dispatch_source = head;
                        end
                    end
                end
                F_RAISE: begin
                    if (val && !raised[src]) begin
                        raised[src] = 1'b1;
                        if (enabled[src]) pend_insert(src);
                    end else if (autoclear[src]) begin
                        flag_drop(src);
                    end
                end
                F_SRC_ENABLE: begin
                    if (enabled[src] != val) begin
                        enabled[src] = val;
                        if (val) begin
                            if (raised[src] && remember[src]) pend_insert(src);
                        end else begin
                            pend_drop(src);
                        end
                    end
                end
                F_FLAG_CLEAR: begin
                    if (val) flag_drop(src);
                end
                F_GLOBAL_EN: gie = val;
                F_RETURN:    ret_latch = 1;
                default: ;
            endcase
            r.active_valid  = in_handler;
            r.active_source = handler;
            r.global_enable = gie;
            r.flags         = raised;
            r.pending_any   = (queued != 0);
            status_due.push_back(r);
        endfunction

        task report(string what, logic [OUT_DATA_W-1:0] got, logic [OUT_DATA_W-1:0] want);
            $display("tb: status mismatch on %s at %0t ns: got %0h, expected %0h",
                     what, $time, got, want);
            mismatches++;
        endtask

        task compare_field(string what, logic [OUT_DATA_W-1:0] got,
                           logic [OUT_DATA_W-1:0] want);
            if (got !== want) report(what, got, want);
        endtask

        task check_status(logic [OUT_DATA_W-1:0] data);
            t_result got;
            t_result want;
            if (status_due.size() == 0) begin
                report("result with nothing outstanding", data, '0);
                return;
            end
            want = status_due.pop_front();
            got  = t_result'(data[$bits(t_result)-1:0]);
            compare_field("dispatched", OUT_DATA_W'(got.dispatched),
                          OUT_DATA_W'(want.dispatched));
            compare_field("dispatch_source", OUT_DATA_W'(got.dispatch_source),
                          OUT_DATA_W'(want.dispatch_source));
            compare_field("returned", OUT_DATA_W'(got.returned),
                          OUT_DATA_W'(want.returned));
            compare_field("return_error", OUT_DATA_W'(got.return_error),
                          OUT_DATA_W'(want.return_error));
            compare_field("active_valid", OUT_DATA_W'(got.active_valid),
                          OUT_DATA_W'(want.active_valid));
            compare_field("active_source", OUT_DATA_W'(got.active_source),
                          OUT_DATA_W'(want.active_source));
            compare_field("global_enable", OUT_DATA_W'(got.global_enable),
                          OUT_DATA_W'(want.global_enable));
            compare_field("flags", OUT_DATA_W'(got.flags), OUT_DATA_W'(want.flags));
            compare_field("pending_any", OUT_DATA_W'(got.pending_any),
                          OUT_DATA_W'(want.pending_any));
            compare_field("padding", OUT_DATA_W'(data[OUT_DATA_W-1:$bits(t_result)]), '0);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // source[3:0], value[4], zero fill above
    logic [IN_USER_W-1:0]  s_axis_tuser;   // func[2:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // dispatched, dispatch_source, returned, return_error, active_valid,
    // active_source, global_enable, flags, pending_any, from bit 0 up
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    irq_status_checker sb;
    int  gap_odds;      // percent chance of a sender gap before a request
    int  stall_odds;    // percent chance per cycle that the receiver starts a stall
    bit  hold_req;      // asks the receiver for one long hold-off
    int  cycle_count;

    nested_priority_interrupt_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: checks every taken result, stalls in random bursts,
    // and serves one long hold-off when asked
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
            if (stall_left == 0) begin
                if (hold_req) begin
                    hold_req   = 0;
                    stall_left = HOLD_CYCLES;
                end else if (stall_odds > 0 && $urandom_range(1, 100) <= stall_odds) begin
                    stall_left = $urandom_range(1, 10);
                end
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one request, keep it up until taken; valid stays high afterwards so
    // that a following request goes out back to back
    task send_request(logic [IN_USER_W-1:0] func, logic [SRC_W-1:0] src, logic val);
        if (gap_odds > 0 && $urandom_range(1, 100) <= gap_odds) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {3'b000, val, src};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_request(func, src, val);
    endtask

    // every result in and the block ready for the next request
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.status_due.size() != 0 || !s_axis_tready) @(posedge i_clk);
    endtask

    task apply_settings(logic [MAP_W-1:0] map, logic [MASK_W-1:0] ac,
                        logic [MASK_W-1:0] rem);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PRIO_MAP;
        i_cfg_data <= map;
        @(posedge i_clk);
        sb.set_register(CFG_PRIO_MAP, map);
        i_cfg_idx  <= CFG_AUTOCLEAR;
        i_cfg_data <= {16'h0000, ac};
        @(posedge i_clk);
        sb.set_register(CFG_AUTOCLEAR, {16'h0000, ac});
        i_cfg_idx  <= CFG_REMEMBER;
        i_cfg_data <= {16'h0000, rem};
        @(posedge i_clk);
        sb.set_register(CFG_REMEMBER, {16'h0000, rem});
        i_cfg_we   <= 1'b0;
    endtask

    // weighted random requests; now and then a whole raise-dispatch-return
    // handler round so that the nesting logic gets exercised
    task run_random(int count);
        int                   k;
        int                   pick;
        logic [SRC_W-1:0]     src;
        logic [IN_USER_W-1:0] func;
        logic                 val;
        k = 0;
        while (k < count) begin
            src  = SRC_W'($urandom_range(0, SOURCES - 1));
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_request(F_RAISE, src, 1'b1);
                send_request(F_SRC_ENABLE, src, 1'b1);
                send_request(F_GLOBAL_EN, src, 1'b1);
                send_request(F_TICK, src, 1'b0);
                send_request(F_TICK, src, 1'b1);
                send_request(F_RETURN, src, 1'b0);
                send_request(F_TICK, src, 1'b0);
                k += 7;
            end else begin
                pick = $urandom_range(0, 99);
                val  = 1'($urandom_range(0, 1));
                if (pick < 30) begin
                    func = F_TICK;
                end else if (pick < 52) begin
                    func = F_RAISE;
                    val  = ($urandom_range(0, 4) != 0);
                end else if (pick < 64) begin
                    func = F_SRC_ENABLE;
                    val  = ($urandom_range(0, 3) != 0);
                end else if (pick < 72) begin
                    func = F_FLAG_CLEAR;
                end else if (pick < 82) begin
                    func = F_GLOBAL_EN;
                    val  = ($urandom_range(0, 4) != 0);
                end else if (pick < 97) begin
                    func = F_RETURN;
                end else begin
                    func = pick[0] ? FUNC_SPARE_A : FUNC_SPARE_B;
                end
                send_request(func, src, val);
                k++;
            end
        end
    endtask

    // drive the nesting stack past full: each step gives only the new source a
    // nonzero level, so it always preempts the handler running before it
    task run_deep_nesting();
        int               k;
        logic [SRC_W-1:0] src;
        logic [MASK_W-1:0] ac;
        // unwind whatever the earlier phases left active
        repeat (SOURCES + 4) begin
            send_request(F_RETURN, SRC_W'($urandom_range(0, SOURCES - 1)),
                         1'($urandom_range(0, 1)));
            send_request(F_TICK, SRC_W'($urandom_range(0, SOURCES - 1)),
                         1'($urandom_range(0, 1)));
        end
        for (k = 0; k < SOURCES; k++) send_request(F_SRC_ENABLE, SRC_W'(k), 1'b0);
        ac = MASK_W'($urandom);
        for (k = 0; k < SOURCES + 2; k++) begin
            src = SRC_W'(k % SOURCES);
            apply_settings(32'h1 << (PRIO_BITS * int'(src)), ac, 16'hFFFF);
            send_request(F_SRC_ENABLE, src, 1'b1);
            send_request(F_FLAG_CLEAR, src, 1'b1);
            send_request(F_RAISE, src, 1'b1);
            send_request(F_GLOBAL_EN, src, 1'b1);
            send_request(F_TICK, src, 1'b0);
            send_request(F_SRC_ENABLE, src, 1'b0);
        end
        repeat (SOURCES + 3) begin
            send_request(F_RETURN, SRC_W'($urandom_range(0, SOURCES - 1)), 1'b0);
            send_request(F_TICK, SRC_W'($urandom_range(0, SOURCES - 1)), 1'b0);
        end
    endtask

    initial begin
        sb            = new();
        gap_odds      = 0;
        stall_odds    = 0;
        hold_req      = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= F_TICK;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_PRIO_MAP;
        i_cfg_data    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, starting from the reset configuration
        gap_odds   = 20;
        stall_odds = 10;
        send_request(F_RETURN, 4'd0, 1'b0);        // return with nothing active
        send_request(F_TICK, 4'd0, 1'b0);
        send_request(FUNC_SPARE_A, 4'd15, 1'b1);   // unassigned codes only report
        send_request(FUNC_SPARE_B, 4'd0, 1'b0);
        // levels 3, 2, 1, 0 repeating from source 0 up
        apply_settings(32'h1B1B_1B1B, 16'hFFFF, 16'hFFFF);
        send_request(F_RAISE, 4'd3, 1'b1);         // raised while disabled
        send_request(F_SRC_ENABLE, 4'd3, 1'b1);    // remembered flag becomes pending
        send_request(F_TICK, 4'd3, 1'b0);          // global enable still off
        send_request(F_GLOBAL_EN, 4'd0, 1'b1);
        send_request(F_TICK, 4'd0, 1'b1);          // enters source 3
        send_request(F_RAISE, 4'd1, 1'b1);
        send_request(F_SRC_ENABLE, 4'd1, 1'b1);
        send_request(F_GLOBAL_EN, 4'd0, 1'b1);
        send_request(F_TICK, 4'd0, 1'b0);          // source 1 preempts
        send_request(F_SRC_ENABLE, 4'd0, 1'b1);
        send_request(F_RAISE, 4'd0, 1'b1);
        send_request(F_GLOBAL_EN, 4'd0, 1'b1);
        send_request(F_TICK, 4'd0, 1'b0);          // source 0 preempts again
        send_request(F_RAISE, 4'd0, 1'b1);         // raise while raised clears
        send_request(F_RAISE, 4'd15, 1'b0);        // low raise
        send_request(F_FLAG_CLEAR, 4'd1, 1'b0);    // clear write of zero does nothing
        send_request(F_FLAG_CLEAR, 4'd1, 1'b1);
        send_request(F_RETURN, 4'd15, 1'b1);
        send_request(F_TICK, 4'd0, 1'b0);
        send_request(F_RETURN, 4'd0, 1'b0);
        send_request(F_TICK, 4'd0, 1'b0);
        send_request(F_RETURN, 4'd0, 1'b0);
        send_request(F_TICK, 4'd0, 1'b0);

        // random phases over several register settings
        gap_odds   = 25;
        stall_odds = 15;
        apply_settings($urandom, MASK_W'($urandom), MASK_W'($urandom));
        run_random(90);

        // everything at zero; the receiver holds off while requests keep coming
        apply_settings('0, '0, '0);
        hold_req = 1;
        run_random(70);

        // everything at ones, and a stretch with no idling on either side
        gap_odds   = 0;
        stall_odds = 0;
        apply_settings('1, '1, '1);
        run_random(70);

        gap_odds   = 20;
        stall_odds = 10;
        run_deep_nesting();

        apply_settings($urandom, 16'h00FF, MASK_W'($urandom));
        run_random(100);

        gap_odds   = 35;
        stall_odds = 25;
        apply_settings($urandom, MASK_W'($urandom), 16'hFF00);
        run_random(90);

        // closing stretch at full rate
        gap_odds   = 0;
        stall_odds = 0;
        apply_settings($urandom, MASK_W'($urandom), MASK_W'($urandom));
        run_random(100);

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
